[hw/rtl/bdc_pkg.sv]
`timescale 1ns / 1ps

package bdc_pkg;

  localparam int SLOTS     = 8;
  localparam int TAG_W     = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = 4;
  localparam int DEF_LIMIT = 5;

  typedef enum logic [2:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_LIST_FWD   = 3'd4,
    K_LIST_BWD   = 3'd5,
    K_NEXT       = 3'd6,
    K_PREV       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // source a cell loads from on the next edge
  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_PREV = 2'd1,
    SEL_NEXT = 2'd2,
    SEL_BUS  = 2'd3
  } cell_sel_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_t;

endpackage

[hw/rtl/bdc_cell.sv]
`timescale 1ns / 1ps

// One storage cell of the chain: holds one tag, takes a neighbor or the bus.
module bdc_cell (
  input  logic                     clk,
  input  bdc_pkg::cell_sel_t       sel,
  input  logic [bdc_pkg::TAG_W-1:0] prev_d,
  input  logic [bdc_pkg::TAG_W-1:0] next_d,
  input  logic [bdc_pkg::TAG_W-1:0] bus_d,
  output logic [bdc_pkg::TAG_W-1:0] q
);

  always_ff @(posedge clk) begin
    case (sel)
      bdc_pkg::SEL_PREV: q <= prev_d;
      bdc_pkg::SEL_NEXT: q <= next_d;
      bdc_pkg::SEL_BUS:  q <= bus_d;
      default:           q <= q;
    endcase
  end

endmodule

[hw/rtl/bounded_deque_with_cursor_unit.sv]
`timescale 1ns / 1ps

// Bounded deque of 16-bit tags with a play cursor.
// Input channel (in_valid/in_ready, kind, song_in) carries one operation per
// transfer; the output channel (out_valid/out_ready, status, song_out, last,
// count_out) returns its results. The config channel (cfg_valid/cfg_ready,
// max_entries) sets the push limit and is always ready; write it only while
// the block is idle.
// Push, pop, next and previous give one result, registered, in the cycle after
// the input transfer; a new item can be taken every cycle as long as the output
// register drains. A list of N entries first enters the list state, then sends
// one tag per cycle while the output register drains, the chain of cells
// rotating by one position each step so that the tag to send sits at a fixed
// cell. After N steps the chain is back in its original order. Input is not
// taken while a list is running.
// Tags live in a row of cells ordered from the head; the cursor is kept as an
// offset from the head, so pushes and pops at the front shift the chain
// instead of moving pointers.
// Reset empties the deque, clears the cursor, sets the limit to 5 and drops
// any pending result. When out_ready is low the result register holds and
// the block waits; nothing is lost.
module bounded_deque_with_cursor_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                kind,
  input  logic [bdc_pkg::TAG_W-1:0] song_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [bdc_pkg::TAG_W-1:0] song_out,
  output logic                      last,
  output logic [bdc_pkg::CNT_W-1:0] count_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [3:0]                max_entries
);

  localparam int SLOTS = bdc_pkg::SLOTS;
  localparam int TAG_W = bdc_pkg::TAG_W;
  localparam int IDX_W = bdc_pkg::IDX_W;
  localparam int CNT_W = bdc_pkg::CNT_W;

  // control state
  bdc_pkg::fsm_t    fsm, fsm_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] cur_off, cur_off_next;
  logic             cur_valid, cur_valid_next;
  logic [3:0]       limit_reg;
  logic             list_bwd, list_bwd_next;
  logic [IDX_W-1:0] list_idx, list_idx_next;
  logic             out_valid_next;

  // result register loads
  logic             out_load;
  logic [1:0]       status_next;
  logic [TAG_W-1:0] song_out_next;
  logic             last_next;

  // cell chain
  bdc_pkg::cell_sel_t cell_sel [SLOTS];
  logic [TAG_W-1:0]   cell_q   [SLOTS];
  logic [TAG_W-1:0]   bus_d;
  logic [IDX_W-1:0]   rd_idx;
  logic [TAG_W-1:0]   rd_data;

  // decoded operation
  bdc_pkg::kind_t   op;
  logic             accept, out_free, list_step;
  logic [CNT_W-1:0] limit;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] off0, off_step;
  logic [CNT_W-1:0] count_m1;

  assign cfg_ready = 1'b1;

  assign op       = bdc_pkg::kind_t'(kind);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (fsm == bdc_pkg::FSM_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign list_step = (fsm == bdc_pkg::FSM_LIST) && out_free;

  // limits above the store size act as the store size
  assign limit    = (limit_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : limit_reg;
  assign is_full  = count >= limit;
  assign is_empty = count == '0;
  assign count_m1 = count - CNT_W'(1);

  // cursor step: an invalid cursor counts as sitting on the head
  always_comb begin
    off0 = (cur_valid && ({1'b0, cur_off} < count)) ? {1'b0, cur_off} : '0;
    if (op == bdc_pkg::K_NEXT) begin
      off_step = (off0 + CNT_W'(1) == count) ? '0 : off0 + CNT_W'(1);
    end else begin
      off_step = (off0 == '0) ? count_m1 : off0 - CNT_W'(1);
    end
  end

  // single read port on the chain
  always_comb begin
    rd_idx = '0;
    if (fsm == bdc_pkg::FSM_LIST) begin
      rd_idx = list_bwd ? count_m1[IDX_W-1:0] : '0;
    end else begin
      case (op)
        bdc_pkg::K_POP_BACK: rd_idx = count_m1[IDX_W-1:0];
        bdc_pkg::K_NEXT,
        bdc_pkg::K_PREV:     rd_idx = off_step[IDX_W-1:0];
        default:             rd_idx = '0;
      endcase
    end
  end

  assign rd_data = cell_q[rd_idx];
  // pushes feed the new tag; list rotation wraps the read cell around
  assign bus_d   = (fsm == bdc_pkg::FSM_IDLE) ? song_in : rd_data;

  // per-cell source selection
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cell_sel[i] = bdc_pkg::SEL_HOLD;
      if (list_step) begin
        if (!list_bwd) begin
          // rotate left over the stored part, head wraps to the tail
          if (CNT_W'(i) < count_m1)       cell_sel[i] = bdc_pkg::SEL_NEXT;
          else if (CNT_W'(i) == count_m1) cell_sel[i] = bdc_pkg::SEL_BUS;
        end else begin
          // rotate right over the stored part, tail wraps to the head
          if (i == 0)                     cell_sel[i] = bdc_pkg::SEL_BUS;
          else if (CNT_W'(i) < count)     cell_sel[i] = bdc_pkg::SEL_PREV;
        end
      end else if (accept) begin
        case (op)
          bdc_pkg::K_PUSH_FRONT: begin
            if (!is_full) cell_sel[i] = (i == 0) ? bdc_pkg::SEL_BUS : bdc_pkg::SEL_PREV;
          end
          bdc_pkg::K_PUSH_BACK: begin
            if (!is_full && CNT_W'(i) == count) cell_sel[i] = bdc_pkg::SEL_BUS;
          end
          bdc_pkg::K_POP_FRONT: begin
            if (!is_empty) cell_sel[i] = bdc_pkg::SEL_NEXT;
          end
          default: cell_sel[i] = bdc_pkg::SEL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic [TAG_W-1:0] prev_d, next_d;
    if (g == 0) begin : g_first
      assign prev_d = bus_d;
    end else begin : g_mid
      assign prev_d = cell_q[g-1];
    end
    if (g == SLOTS - 1) begin : g_last
      assign next_d = bus_d;
    end else begin : g_inner
      assign next_d = cell_q[g+1];
    end
    bdc_cell u_cell (
      .clk    (clk),
      .sel    (cell_sel[g]),
      .prev_d (prev_d),
      .next_d (next_d),
      .bus_d  (bus_d),
      .q      (cell_q[g])
    );
  end

  // next state and results
  always_comb begin
    fsm_next       = fsm;
    count_next     = count;
    cur_off_next   = cur_off;
    cur_valid_next = cur_valid;
    list_bwd_next  = list_bwd;
    list_idx_next  = list_idx;
    out_load       = 1'b0;
    status_next    = bdc_pkg::ST_OK;
    song_out_next  = '0;
    last_next      = 1'b1;

    if (list_step) begin
      out_load      = 1'b1;
      song_out_next = rd_data;
      last_next     = ({1'b0, list_idx} == count_m1);
      list_idx_next = list_idx + IDX_W'(1);
      if (last_next) fsm_next = bdc_pkg::FSM_IDLE;
    end else if (accept) begin
      out_load = 1'b1;
      case (op)
        bdc_pkg::K_PUSH_FRONT,
        bdc_pkg::K_PUSH_BACK: begin
          if (is_full) begin
            status_next = bdc_pkg::ST_FULL;
          end else begin
            song_out_next = song_in;
            count_next    = count + CNT_W'(1);
            if (!cur_valid) begin
              cur_off_next   = '0;
              cur_valid_next = 1'b1;
            end else if (op == bdc_pkg::K_PUSH_FRONT) begin
              cur_off_next = cur_off + IDX_W'(1);
            end
          end
        end
        bdc_pkg::K_POP_FRONT,
        bdc_pkg::K_POP_BACK: begin
          if (is_empty) begin
            status_next = bdc_pkg::ST_EMPTY;
          end else begin
            song_out_next  = rd_data;
            count_next     = count_m1;
            cur_off_next   = '0;
            cur_valid_next = (count_m1 != '0);
          end
        end
        bdc_pkg::K_LIST_FWD,
        bdc_pkg::K_LIST_BWD: begin
          if (is_empty) begin
            status_next = bdc_pkg::ST_EMPTY;
          end else begin
            out_load      = 1'b0;
            fsm_next      = bdc_pkg::FSM_LIST;
            list_bwd_next = (op == bdc_pkg::K_LIST_BWD);
            list_idx_next = '0;
          end
        end
        default: begin
          // cursor next / previous
          if (is_empty) begin
            status_next = bdc_pkg::ST_EMPTY;
          end else begin
            song_out_next  = rd_data;
            cur_off_next   = off_step[IDX_W-1:0];
            cur_valid_next = 1'b1;
          end
        end
      endcase
    end

    if (out_load)       out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= bdc_pkg::FSM_IDLE;
      count     <= '0;
      cur_off   <= '0;
      cur_valid <= 1'b0;
      list_bwd  <= 1'b0;
      list_idx  <= '0;
      out_valid <= 1'b0;
      limit_reg <= 4'(bdc_pkg::DEF_LIMIT);
    end else begin
      fsm       <= fsm_next;
      count     <= count_next;
      cur_off   <= cur_off_next;
      cur_valid <= cur_valid_next;
      list_bwd  <= list_bwd_next;
      list_idx  <= list_idx_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) limit_reg <= max_entries;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= status_next;
      song_out  <= song_out_next;
      last      <= last_next;
      count_out <= count_next;
    end
  end

endmodule
